### rtl/core/sgt_pkg.sv
// ----------------------------------------------------------------------------
// sgt_pkg
// Shared constants for the Scharr gradient tensor block: field widths,
// register indexes and filter coefficients.
// ----------------------------------------------------------------------------
package sgt_pkg;

    localparam int MAX_WIDTH = 2048;

    localparam int PIX_W    = 8;
    localparam int COL_W    = 11;
    localparam int ROW_W    = 12;
    localparam int WIDTH_W  = 12;
    localparam int HEIGHT_W = 13;
    localparam int SQ_W     = 10;
    localparam int XY_W     = 11;
    localparam int GRAD_W   = 17;
    localparam int PROD_W   = 32;
    localparam int SHIFT    = 20;

    localparam int CFG_IDX_W  = 2;
    localparam int CFG_DATA_W = 13;

    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_IMAGE_HEIGHT = 2'd1;

    localparam logic [WIDTH_W-1:0]  WIDTH_MIN   = 12'd18;
    localparam logic [WIDTH_W-1:0]  WIDTH_MAX   = 12'(MAX_WIDTH);
    localparam logic [WIDTH_W-1:0]  WIDTH_RST   = 12'd640;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MIN  = 13'd3;
    localparam logic [HEIGHT_W-1:0] HEIGHT_MAX  = 13'd4096;
    localparam logic [HEIGHT_W-1:0] HEIGHT_RST  = 13'd480;

    localparam logic [6:0] K_SIDE = 7'd24;
    localparam logic [6:0] K_MID  = 7'd80;

    localparam logic [SQ_W-1:0] SQ_MAX = 10'd1016;

endpackage

### rtl/core/sgt_channels.sv
// ----------------------------------------------------------------------------
// sgt channels
// Valid/ready channel interfaces: pixel input, result output and
// configuration write.
// ----------------------------------------------------------------------------
interface sgt_pixel_if
    import sgt_pkg::*;
;
    logic             valid;
    logic             ready;
    logic [PIX_W-1:0] pixel;

    modport source (output valid, output pixel, input ready);
    modport sink   (input valid, input pixel, output ready);
endinterface

interface sgt_result_if
    import sgt_pkg::*;
;
    logic                    valid;
    logic                    ready;
    logic [ROW_W-1:0]        out_row;
    logic [COL_W-1:0]        out_col;
    logic [SQ_W-1:0]         grad_xx;
    logic [SQ_W-1:0]         grad_yy;
    logic signed [XY_W-1:0]  grad_xy;

    modport source (output valid, output out_row, output out_col, output grad_xx,
                    output grad_yy, output grad_xy, input ready);
    modport sink   (input valid, input out_row, input out_col, input grad_xx,
                    input grad_yy, input grad_xy, output ready);
endinterface

interface sgt_cfg_if
    import sgt_pkg::*;
;
    logic                  valid;
    logic                  ready;
    logic [CFG_IDX_W-1:0]  index;
    logic [CFG_DATA_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

### rtl/core/sgt_ram.sv
// ----------------------------------------------------------------------------
// sgt_ram
// Generic simple dual-port RAM: one write port, one read port with
// registered read data that holds while the read enable is low.
// ----------------------------------------------------------------------------
module sgt_ram #(
    parameter int  WIDTH = 8,
    parameter int  DEPTH = 2048,
    localparam int AW    = $clog2(DEPTH)
) (
    input  logic             clk,
    input  logic             wr_en,
    input  logic [AW-1:0]    wr_addr,
    input  logic [WIDTH-1:0] wr_data,
    input  logic             rd_en,
    input  logic [AW-1:0]    rd_addr,
    output logic [WIDTH-1:0] rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

### rtl/core/scharr_gradient_tensor.sv
// ----------------------------------------------------------------------------
// scharr_gradient_tensor
// Streaming 3x3 Scharr gradient and structure tensor terms over a raster
// pixel stream, with two line RAMs and a small window register file.
// ----------------------------------------------------------------------------
// The block takes one pixel per clock in raster order and sustains that rate
// indefinitely while the result side keeps up. Each pixel reads both line RAMs
// at its column on the cycle it is transferred; when stage 1 advances, the
// window is updated, the pixel is written back and the gradients are formed
// into stage 2; stage 3 forms the three products into the output register.
// Border positions (first two rows and columns of the window corner) give no
// result. Width and height are taken from the configuration registers,
// saturated to 18..2048 and 3..4096, and should be changed only while the
// block is idle. The line RAMs need no clearing after reset.
// ----------------------------------------------------------------------------
module scharr_gradient_tensor
    import sgt_pkg::*;
(
    input  logic          clk,
    input  logic          rst_n,
    sgt_pixel_if.sink     pixels,
    sgt_result_if.source  results,
    sgt_cfg_if.sink       cfg
);

    // configuration
    logic [WIDTH_W-1:0]  width_reg;
    logic [HEIGHT_W-1:0] height_reg;
    logic [WIDTH_W-1:0]  eff_w;
    logic [HEIGHT_W-1:0] eff_h;

    // position counters
    logic [COL_W-1:0]    col_reg, col_next;
    logic [ROW_W-1:0]    row_reg, row_next;
    logic [COL_W-1:0]    cur_col;
    logic [ROW_W-1:0]    cur_row;
    logic [HEIGHT_W-1:0] row_tmp;
    logic [WIDTH_W-1:0]  col_inc;
    logic [HEIGHT_W-1:0] row_inc;

    // stage 1: line RAM data valid
    logic                s1_valid_reg, s1_valid_next;
    logic [PIX_W-1:0]    s1_pix_reg;
    logic [COL_W-1:0]    s1_col_reg;
    logic [ROW_W-1:0]    s1_row_reg;
    logic                s1_emit;
    logic [PIX_W-1:0]    upper_rd, lower_rd;

    // window: left column [0..2], middle column [3..5], top to bottom
    logic [PIX_W-1:0]    win_reg [6];

    // stage 2: gradients
    logic                    s2_valid_reg, s2_valid_next;
    logic signed [GRAD_W-1:0] s2_gx_reg, s2_gy_reg;
    logic [ROW_W-1:0]        s2_row_reg;
    logic [COL_W-1:0]        s2_col_reg;
    logic [14:0]             gx_pos, gx_neg, gy_pos, gy_neg;
    logic signed [GRAD_W-1:0] gx_next, gy_next;

    // stage 3: output register
    logic                    s3_valid_reg, s3_valid_next;
    logic [ROW_W-1:0]        s3_row_reg;
    logic [COL_W-1:0]        s3_col_reg;
    logic [SQ_W-1:0]         s3_xx_reg, s3_yy_reg;
    logic signed [XY_W-1:0]  s3_xy_reg;
    logic signed [PROD_W-1:0] prod_xx, prod_yy, prod_xy;

    // handshake
    logic s3_free, s2_free, s1_fire, accept;

    assign s3_free = !s3_valid_reg || results.ready;
    assign s2_free = !s2_valid_reg || s3_free;
    assign s1_fire = s1_valid_reg && s2_free;
    assign pixels.ready = !s1_valid_reg || s2_free;
    assign accept = pixels.valid && pixels.ready;

    // ---------------- configuration ----------------
    assign cfg.ready = 1'b1;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            width_reg  <= WIDTH_RST;
            height_reg <= HEIGHT_RST;
        end
        else if (cfg.valid)
        begin
            case (cfg.index)
                CFG_IMAGE_WIDTH:  width_reg  <= cfg.data[WIDTH_W-1:0];
                CFG_IMAGE_HEIGHT: height_reg <= cfg.data[HEIGHT_W-1:0];
                default:          ;
            endcase
        end
    end

    always_comb
    begin
        if (width_reg < WIDTH_MIN)
            eff_w = WIDTH_MIN;
        else if (width_reg > WIDTH_MAX)
            eff_w = WIDTH_MAX;
        else
            eff_w = width_reg;

        if (height_reg < HEIGHT_MIN)
            eff_h = HEIGHT_MIN;
        else if (height_reg > HEIGHT_MAX)
            eff_h = HEIGHT_MAX;
        else
            eff_h = height_reg;
    end

    // ---------------- position ----------------
    always_comb
    begin
        // wrap counts left beyond a smaller frame by a register write
        if (WIDTH_W'(col_reg) >= eff_w)
        begin
            cur_col = '0;
            row_tmp = HEIGHT_W'(row_reg) + 13'd1;
        end
        else
        begin
            cur_col = col_reg;
            row_tmp = HEIGHT_W'(row_reg);
        end
        cur_row = (row_tmp >= eff_h) ? '0 : row_tmp[ROW_W-1:0];

        col_inc = WIDTH_W'(cur_col) + 12'd1;
        row_inc = HEIGHT_W'(cur_row) + 13'd1;
        if (col_inc >= eff_w)
        begin
            col_next = '0;
            row_next = (row_inc >= eff_h) ? '0 : row_inc[ROW_W-1:0];
        end
        else
        begin
            col_next = col_inc[COL_W-1:0];
            row_next = cur_row;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            col_reg <= '0;
            row_reg <= '0;
        end
        else if (accept)
        begin
            col_reg <= col_next;
            row_reg <= row_next;
        end
    end

    // ---------------- line RAMs ----------------
    sgt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_upper (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (lower_rd),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (upper_rd)
    );

    sgt_ram #(.WIDTH(PIX_W), .DEPTH(MAX_WIDTH)) u_lower (
        .clk     (clk),
        .wr_en   (s1_fire),
        .wr_addr (s1_col_reg),
        .wr_data (s1_pix_reg),
        .rd_en   (accept),
        .rd_addr (cur_col),
        .rd_data (lower_rd)
    );

    // ---------------- stage 1 ----------------
    always_comb
    begin
        if (accept)
            s1_valid_next = 1'b1;
        else if (s1_fire)
            s1_valid_next = 1'b0;
        else
            s1_valid_next = s1_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s1_valid_reg <= 1'b0;
        else
            s1_valid_reg <= s1_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_pix_reg <= pixels.pixel;
            s1_col_reg <= cur_col;
            s1_row_reg <= cur_row;
        end
    end

    assign s1_emit = (s1_row_reg >= 12'd2) && (s1_col_reg >= 11'd2);

    // right column: top from upper RAM, centre from lower RAM, bottom is the pixel
    always_comb
    begin
        gx_pos = K_SIDE * (15'(win_reg[0]) + 15'(win_reg[2])) + K_MID * 15'(win_reg[1]);
        gx_neg = K_SIDE * (15'(upper_rd) + 15'(s1_pix_reg)) + K_MID * 15'(lower_rd);
        gy_pos = K_SIDE * (15'(win_reg[0]) + 15'(upper_rd)) + K_MID * 15'(win_reg[3]);
        gy_neg = K_SIDE * (15'(win_reg[2]) + 15'(s1_pix_reg)) + K_MID * 15'(win_reg[5]);
        gx_next = $signed({2'b00, gx_pos}) - $signed({2'b00, gx_neg});
        gy_next = $signed({2'b00, gy_pos}) - $signed({2'b00, gy_neg});
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int i = 0; i < 6; i++)
                win_reg[i] <= '0;
        end
        else if (s1_fire)
        begin
            // advance the window by one column
            win_reg[0] <= win_reg[3];
            win_reg[1] <= win_reg[4];
            win_reg[2] <= win_reg[5];
            win_reg[3] <= upper_rd;
            win_reg[4] <= lower_rd;
            win_reg[5] <= s1_pix_reg;
        end
    end

    // ---------------- stage 2 ----------------
    assign s2_valid_next = s2_free ? (s1_fire && s1_emit) : s2_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s2_valid_reg <= 1'b0;
        else
            s2_valid_reg <= s2_valid_next;
    end

    always_ff @(posedge clk)
    begin
        if (s1_fire && s2_free)
        begin
            s2_gx_reg  <= gx_next;
            s2_gy_reg  <= gy_next;
            s2_row_reg <= s1_row_reg - 12'd1;
            s2_col_reg <= s1_col_reg - 11'd1;
        end
    end

    // ---------------- stage 3 ----------------
    assign prod_xx = PROD_W'(s2_gx_reg) * PROD_W'(s2_gx_reg);
    assign prod_yy = PROD_W'(s2_gy_reg) * PROD_W'(s2_gy_reg);
    assign prod_xy = PROD_W'(s2_gx_reg) * PROD_W'(s2_gy_reg);

    assign s3_valid_next = s3_free ? s2_valid_reg : s3_valid_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            s3_valid_reg <= 1'b0;
        else
            s3_valid_reg <= s3_valid_next;
    end

    // bit slices of the two's complement product floor toward minus infinity
    always_ff @(posedge clk)
    begin
        if (s3_free && s2_valid_reg)
        begin
            s3_row_reg <= s2_row_reg;
            s3_col_reg <= s2_col_reg;
            s3_xx_reg  <= prod_xx[SHIFT+SQ_W-1:SHIFT];
            s3_yy_reg  <= prod_yy[SHIFT+SQ_W-1:SHIFT];
            s3_xy_reg  <= prod_xy[SHIFT+XY_W-1:SHIFT];
        end
    end

    assign results.valid   = s3_valid_reg;
    assign results.out_row = s3_row_reg;
    assign results.out_col = s3_col_reg;
    assign results.grad_xx = s3_xx_reg;
    assign results.grad_yy = s3_yy_reg;
    assign results.grad_xy = s3_xy_reg;

    // ---------------- assertions ----------------
    a_ram_no_collision : assert property (@(posedge clk) disable iff (!rst_n)
        (accept && s1_fire) |-> (cur_col != s1_col_reg))
        else $error("line RAM read and write hit the same column");

    a_accept_loads_s1 : assert property (@(posedge clk) disable iff (!rst_n)
        accept |=> s1_valid_reg)
        else $error("transferred pixel did not reach stage 1");

    a_result_inner : assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_row_reg != '0) && (s3_col_reg != '0))
        else $error("result issued for a border position");

    a_result_range : assert property (@(posedge clk) disable iff (!rst_n)
        s3_valid_reg |-> (s3_xx_reg <= SQ_MAX) && (s3_yy_reg <= SQ_MAX))
        else $error("squared gradient out of range");

    a_stall_holds : assert property (@(posedge clk) disable iff (!rst_n)
        (s2_valid_reg && !s3_free) |=> s2_valid_reg && $stable(s2_gx_reg))
        else $error("stage 2 lost data under stall");

endmodule
